// ===== sv/sb2da_pkg.sv =====
// shared types and constants for the signed binary to decimal ascii converter
`timescale 1ns / 1ps
package sb2da_pkg;

	// decimal digits held for a magnitude of up to 2^63
	localparam int DIGIT_DEPTH = 19;
	localparam int BCD_W       = 4 * DIGIT_DEPTH;
	localparam int DCNT_W      = 5;
	localparam int CHAR_W      = 6;

	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

	// handoff from the converter to the character emitter
	typedef struct packed {
		logic done;
		logic negative;
	} conv_result_t;

endpackage

// ===== sv/sb2da_dabble.sv =====
// shift-and-add-3 converter: one magnitude bit per cycle into a bcd register
`timescale 1ns / 1ps
module sb2da_dabble #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [VALUE_WIDTH-1:0]       raw,
	output logic                         idle,
	output sb2da_pkg::conv_result_t      result,
	output logic [sb2da_pkg::BCD_W-1:0]  bcd
);

	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	typedef enum logic [1:0] {
		CONV_IDLE = 2'b01,
		CONV_RUN  = 2'b10
	} conv_state_t;

	conv_state_t                   state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [VALUE_WIDTH-1:0]        mag_q;
	logic [sb2da_pkg::BCD_W-1:0]   bcd_q;
	logic [sb2da_pkg::BCD_W-1:0]   bcd_adj;
	logic                          neg_q;
	logic                          done_q;
	logic                          sign;
	logic [VALUE_WIDTH-1:0]        mag_in;

	assign sign   = raw[VALUE_WIDTH-1];
	assign mag_in = sign ? (~raw + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

	// every digit of five or more gets three added before the shift
	always_comb begin
		for (int i = 0; i < sb2da_pkg::DIGIT_DEPTH; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CONV_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			neg_q   <= 1'b0;
		end else begin
			done_q <= (state_q == CONV_RUN) && (cnt_q == CNT_W'(1));
			case (state_q)
				CONV_IDLE: begin
					if (start) begin
						state_q <= CONV_RUN;
						cnt_q   <= CNT_W'(VALUE_WIDTH);
						neg_q   <= sign;
					end
				end
				CONV_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == CNT_W'(1)) begin
						state_q <= CONV_IDLE;
					end
				end
				default: begin
					state_q <= CONV_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == CONV_IDLE && start) begin
			mag_q <= mag_in;
			bcd_q <= '0;
		end else if (state_q == CONV_RUN) begin
			mag_q <= mag_q << 1;
			bcd_q <= {bcd_adj[sb2da_pkg::BCD_W-2:0], mag_q[VALUE_WIDTH-1]};
		end
	end

	assign idle            = (state_q == CONV_IDLE);
	assign result.done     = done_q;
	assign result.negative = neg_q;
	assign bcd             = bcd_q;

endmodule

// ===== sv/sb2da_emit.sv =====
// character emitter: drops leading zeros, then sends sign and digits one per item
`timescale 1ns / 1ps
module sb2da_emit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  sb2da_pkg::conv_result_t           result,
	input  logic [sb2da_pkg::BCD_W-1:0]       bcd,
	output logic                              idle,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sb2da_pkg::CHAR_W-1:0]      out_char,
	output logic                              out_last
);

	typedef enum logic [3:0] {
		EM_IDLE  = 4'b0001,
		EM_SKIP  = 4'b0010,
		EM_SIGN  = 4'b0100,
		EM_DIGIT = 4'b1000
	} emit_state_t;

	emit_state_t                          state_q;
	logic [sb2da_pkg::BCD_W-1:0]          bcd_q;
	logic [sb2da_pkg::DCNT_W-1:0]         rem_q;
	logic                                 neg_q;
	logic                                 valid_q;
	logic [sb2da_pkg::CHAR_W-1:0]         char_q;
	logic                                 last_q;
	logic [3:0]                           top_digit;
	logic                                 slot_free;
	logic                                 load;

	assign top_digit = bcd_q[sb2da_pkg::BCD_W-1 -: 4];
	assign slot_free = !valid_q || out_ready;
	assign load      = slot_free && (state_q == EM_SIGN || state_q == EM_DIGIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			rem_q   <= '0;
			neg_q   <= 1'b0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
			case (state_q)
				EM_IDLE: begin
					if (result.done) begin
						state_q <= EM_SKIP;
						rem_q   <= sb2da_pkg::DCNT_W'(sb2da_pkg::DIGIT_DEPTH);
						neg_q   <= result.negative;
					end
				end
				EM_SKIP: begin
					// keep at least one digit so zero prints as "0"
					if (top_digit == 4'd0 && rem_q != sb2da_pkg::DCNT_W'(1)) begin
						rem_q <= rem_q - 1'b1;
					end else begin
						state_q <= neg_q ? EM_SIGN : EM_DIGIT;
					end
				end
				EM_SIGN: begin
					if (slot_free) begin
						state_q <= EM_DIGIT;
					end
				end
				EM_DIGIT: begin
					if (slot_free) begin
						rem_q <= rem_q - 1'b1;
						if (rem_q == sb2da_pkg::DCNT_W'(1)) begin
							state_q <= EM_IDLE;
						end
					end
				end
				default: begin
					state_q <= EM_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == EM_IDLE && result.done) begin
			bcd_q <= bcd;
		end else if (state_q == EM_SKIP && top_digit == 4'd0
			&& rem_q != sb2da_pkg::DCNT_W'(1)) begin
			bcd_q <= bcd_q << 4;
		end else if (state_q == EM_DIGIT && slot_free) begin
			bcd_q <= bcd_q << 4;
		end
		if (state_q == EM_SIGN && slot_free) begin
			char_q <= sb2da_pkg::ASCII_MINUS;
			last_q <= 1'b0;
		end else if (state_q == EM_DIGIT && slot_free) begin
			char_q <= sb2da_pkg::ASCII_ZERO | {2'b00, top_digit};
			last_q <= (rem_q == sb2da_pkg::DCNT_W'(1));
		end
	end

	assign idle      = (state_q == EM_IDLE);
	assign out_valid = valid_q;
	assign out_char  = char_q;
	assign out_last  = last_q;

endmodule

// ===== sv/signed_binary_to_decimal_ascii.sv =====
// top level of the signed binary to decimal ascii converter
`timescale 1ns / 1ps
// Converts one signed integer per input item into its decimal text, sent as
// one character per output item, most significant first, with a leading '-'
// for a negative value and no leading zeros (zero gives "0"). The final
// character of each number has m_tlast set.
// Input channel s_*: tdata carries the value; only its low VALUE_WIDTH bits
// count, bit VALUE_WIDTH-1 being the sign. Output channel m_*: tdata carries
// the ascii code in its low six bits.
// Flow: the shift-and-add-3 converter takes one input bit per cycle and
// then registers a done flag for the handoff. The emitter drops one leading
// zero digit per cycle (up to 18 digits), then picks the first character,
// and sends one character per cycle when the receiver takes each at once.
// s_tready is high only when both the converter and the emitter are idle
// and no handoff is under way.
// Reset clears all control state; the block comes up idle with no output
// pending. A stalled receiver holds the current character in the output
// register, and the emitter waits until that register is free.
module signed_binary_to_decimal_ascii #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // value[63:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // character[5:0], zero[7:6]
	output logic        m_tlast
);

	logic                              conv_idle;
	logic                              emit_idle;
	logic                              start;
	sb2da_pkg::conv_result_t           result;
	logic [sb2da_pkg::BCD_W-1:0]       bcd;
	logic [sb2da_pkg::CHAR_W-1:0]      out_char;

	assign s_tready = conv_idle && emit_idle && !result.done;
	assign start    = s_tvalid && s_tready;

	sb2da_dabble #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.raw    (s_tdata[VALUE_WIDTH-1:0]),
		.idle   (conv_idle),
		.result (result),
		.bcd    (bcd)
	);

	sb2da_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.result    (result),
		.bcd       (bcd),
		.idle      (emit_idle),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (out_char),
		.out_last  (m_tlast)
	);

	assign m_tdata = {2'b00, out_char};

	// the converter hands over only to an idle emitter
	assert property (@(posedge clk) disable iff (!arst_n)
		result.done |-> emit_idle)
		else $error("conversion finished while emitter busy");

	// an accepted item closes the input until it is worked off
	assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_tready)
		else $error("input reopened right after an accepted item");

	// a minus sign is never the final character
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_char == sb2da_pkg::ASCII_MINUS) |-> !m_tlast)
		else $error("minus sign flagged as last character");

	// while a non-final character is pending, the input stays closed
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> !s_tready)
		else $error("input open while a number is still being sent");

endmodule

// ===== bench/decimal_text_checker.sv =====
// watches both streams of the decimal ascii converter and checks every character
`timescale 1ns / 1ps
module decimal_text_checker #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // value[63:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // character[5:0], zero[7:6]
	input  logic        m_tlast,
	output int          errors,
	output int          pending,
	output int          values_seen,
	output int          negatives_seen,
	output int          chars_seen
);

	typedef struct packed {
		logic [sb2da_pkg::CHAR_W-1:0] code;
		logic                         last;
	} text_char_t;

	text_char_t expected_text [$];

	// predicted text of one value, most significant digit first
	task automatic queue_decimal_text(input logic [63:0] raw_in);
		logic [63:0] mask;
		logic [63:0] raw;
		logic [63:0] mag;
		logic        neg;
		logic [3:0]  digits [sb2da_pkg::DIGIT_DEPTH];
		int          n;
		text_char_t  c;
		mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
		raw  = raw_in & mask;
		neg  = raw[VALUE_WIDTH-1];
		// two's complement negation works for the most negative value too
		mag  = neg ? ((~raw + 64'd1) & mask) : raw;
		n = 0;
		while (n == 0 || (mag != 0 && n < sb2da_pkg::DIGIT_DEPTH)) begin
			digits[n] = 4'(mag % 64'd10);
			mag = mag / 64'd10;
			n++;
		end
		if (neg) begin
			c.code = sb2da_pkg::ASCII_MINUS;
			c.last = 1'b0;
			expected_text.push_back(c);
			negatives_seen++;
		end
		for (int k = n - 1; k >= 0; k--) begin
			c.code = sb2da_pkg::ASCII_ZERO + {2'b00, digits[k]};
			c.last = (k == 0);
			expected_text.push_back(c);
		end
	endtask

	always @(posedge clk) begin
		text_char_t want;
		if (!arst_n) begin
			errors = 0;
			pending = 0;
			values_seen = 0;
			negatives_seen = 0;
			chars_seen = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				queue_decimal_text(s_tdata);
				values_seen++;
			end
			if (m_tvalid && m_tready) begin
				chars_seen++;
				if (expected_text.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected character %0d last %b", $time,
							m_tdata[sb2da_pkg::CHAR_W-1:0], m_tlast);
					errors++;
				end else begin
					want = expected_text.pop_front();
					if (m_tdata[sb2da_pkg::CHAR_W-1:0] !== want.code
						|| m_tlast !== want.last) begin
						if (errors < 10)
							$display("%0t: character %0d last %b, expected %0d last %b",
								$time, m_tdata[sb2da_pkg::CHAR_W-1:0], m_tlast,
								want.code, want.last);
						errors++;
					end
				end
			end
			pending = expected_text.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// stimulus and verdict for the signed binary to decimal ascii converter
`timescale 1ns / 1ps
module testbench;

	localparam int VALUE_WIDTH  = 64;
	localparam int RANDOM_ITEMS = 210;
	localparam int DRAIN_AT     = 100;
	localparam int QUIET_FROM   = 175;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;

	int errors;
	int pending;
	int values_seen;
	int negatives_seen;
	int chars_seen;
	bit quiet = 1'b0;

	always #5 clk = ~clk;

	signed_binary_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	decimal_text_checker #(.VALUE_WIDTH(VALUE_WIDTH)) text_check (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.errors(errors), .pending(pending), .values_seen(values_seen),
		.negatives_seen(negatives_seen), .chars_seen(chars_seen)
	);

	// s_tready only depends on registers, so it is settled at the falling edge
	task automatic send_value(input logic [63:0] v);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(negedge clk);
		while (!s_tready) @(negedge clk);
		@(posedge clk);
	endtask

	// hold the input until every predicted character has come out
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		logic [63:0] p;
		int pick;
		pick = $urandom_range(0, 9);
		v = {$urandom, $urandom};
		if (pick < 4) begin
			// spread over every text length
			v = v >> $urandom_range(0, 63);
			if ($urandom_range(0, 1)) v = -v;
		end else if (pick < 6) begin
			// around a power of ten, where the digit count changes
			p = 64'd1;
			repeat ($urandom_range(0, 18)) p = p * 10;
			v = p + $urandom_range(0, 2) - 1;
			if ($urandom_range(0, 1)) v = -v;
		end
		return v;
	endfunction

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 64'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_value(64'd0);
		send_value(64'd1);
		send_value(-64'sd1);
		send_value(64'd5);
		send_value(-64'sd7);
		send_value(64'd9);
		send_value(64'd10);
		send_value(-64'sd10);
		send_value(64'd99);
		send_value(-64'sd100);
		send_value(64'd1000000);
		send_value(64'd999999999999999999);
		send_value(64'd1000000000000000000);
		send_value(-64'sd1000000000000000000);
		send_value(64'd1234567890123456789);
		send_value(-64'sd1234567890123456789);
		send_value(64'h7fff_ffff_ffff_ffff);
		send_value(64'h7fff_ffff_ffff_fffe);
		send_value(64'h8000_0000_0000_0000);
		send_value(64'h8000_0000_0000_0001);
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == DRAIN_AT) wait_drained();
			if (i == QUIET_FROM) quiet = 1'b1;
			send_value(random_value());
		end
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);

		$display("converted %0d values (%0d negative), %0d characters checked",
			values_seen, negatives_seen, chars_seen);
		$display("extremes, powers of ten and all text lengths with random stalls");
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// receiver stalls in bursts
	initial begin
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
